/* rtl/cdta_pkg.sv */
// ----------------------------------------------------------------------------
// cdta_pkg
// Shared types, constants and the month-length table for the calendar
// date-time adder.
// ----------------------------------------------------------------------------
package cdta_pkg;

   // Width of every working value held during normalization.
   localparam int unsigned WORK_W = 9;

   typedef logic [WORK_W-1:0] work_type;

   localparam work_type MINUTES_PER_HOUR = 9'd60;
   localparam work_type HOURS_PER_DAY    = 9'd24;
   localparam work_type MONTHS_PER_YEAR  = 9'd12;
   localparam work_type YEARS_PER_CENT   = 9'd100;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [5:0] base_minutes;
      logic [4:0] base_hours;
      logic [4:0] base_days;
      logic [3:0] base_months;
      logic [6:0] base_years;
      logic [7:0] add_minutes;
      logic [7:0] add_hours;
      logic [7:0] add_days;
      logic [7:0] add_months;
      logic [6:0] add_years;
   } req_type;

   typedef struct packed {
      logic [5:0] sum_minutes;
      logic [4:0] sum_hours;
      logic [4:0] sum_days;
      logic [3:0] sum_months;
      logic [6:0] sum_years;
      logic       century_out;
   } rsp_type;

   // Operands of the shared compare and subtract unit.
   typedef struct packed {
      work_type minuend;
      work_type subtrahend;
   } sub_op_type;

   // Result of the shared unit: difference, greater-or-equal, greater-than.
   typedef struct packed {
      work_type diff;
      logic     ge;
      logic     gt;
   } sub_res_type;

   // Days in a month; February has 29 days in a leap year.
   function automatic work_type month_len(input logic [3:0] month, input logic leap);
      work_type len;
      case (month)
         MONTH_FEB: len = leap ? 9'd29 : 9'd28;
         4'd4:      len = 9'd30;
         4'd6:      len = 9'd30;
         4'd9:      len = 9'd30;
         4'd11:     len = 9'd30;
         default:   len = 9'd31;
      endcase
      return len;
   endfunction

endpackage

/* rtl/cdta_sub_unit.sv */
// ----------------------------------------------------------------------------
// cdta_sub_unit
// Shared compare and subtract unit used by every normalization step.
// ----------------------------------------------------------------------------
module cdta_sub_unit (
   input  cdta_pkg::sub_op_type  op,
   output cdta_pkg::sub_res_type res
);

   logic [cdta_pkg::WORK_W:0] full;

   // The extra top bit is the borrow out of the subtraction.
   assign full = {1'b0, op.minuend} - {1'b0, op.subtrahend};

   assign res.diff = full[cdta_pkg::WORK_W-1:0];
   assign res.ge   = ~full[cdta_pkg::WORK_W];
   assign res.gt   = ~full[cdta_pkg::WORK_W] & (full[cdta_pkg::WORK_W-1:0] != '0);

endmodule

/* rtl/calendar_date_time_adder_top.sv */
// ----------------------------------------------------------------------------
// calendar_date_time_adder_top
// Adds an interval to a base date-time and returns the normalized sum.
// ----------------------------------------------------------------------------
//
// Channel    Ports                       Direction  Transfer
// request    start, busy, req_data       in         start high while busy low
// response   rsp_valid, rsp_data         out        one-cycle strobe, no stall
//
// A request is accepted when start is high while busy is low. The sequencer
// then walks through five phases (minutes, hours, days, months, years), and
// each phase does one subtraction per carry or rollover and moves on once
// its value is in range. All subtractions go through the single compare and
// subtract unit. The response strobe is registered and follows in the cycle
// after the last phase. Busy stays high from acceptance until the cycle of
// the response strobe, in which a new request may already be accepted. Reset
// is synchronous and returns the sequencer to idle with no response pending.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
module calendar_date_time_adder_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cdta_pkg::req_type req_data,
   output logic              rsp_valid,
   output cdta_pkg::rsp_type rsp_data
);

   // One-hot sequencer states: idle and one per normalization phase.
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MIN  = 6'b000010,
      ST_HR   = 6'b000100,
      ST_DAY  = 6'b001000,
      ST_MON  = 6'b010000,
      ST_YR   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Working registers. Months hold the calendar month (1 to 12) during the
   // day phase and the zero-based month total afterwards.
   cdta_pkg::work_type min_ff, min_in;
   cdta_pkg::work_type hr_ff,  hr_in;
   cdta_pkg::work_type day_ff, day_in;
   cdta_pkg::work_type mon_ff, mon_in;
   cdta_pkg::work_type yr_ff,  yr_in;
   logic [7:0]         add_mon_ff, add_mon_in;
   logic [6:0]         add_yr_ff,  add_yr_in;
   logic               cent_ff,    cent_in;

   logic               rsp_valid_ff, rsp_valid_in;
   cdta_pkg::rsp_type  rsp_data_ff,  rsp_data_in;

   cdta_pkg::sub_op_type  sub_op;
   cdta_pkg::sub_res_type sub_res;
   cdta_pkg::work_type    dim;
   logic [3:0]            base_mon;
   logic                  base_mon_wrap;

   // The month length follows the running year total, which already holds
   // the carries from earlier month rollovers.
   assign dim = cdta_pkg::month_len(mon_ff[3:0], yr_ff[1:0] == 2'b00);

   // A base month of zero is taken as January; one above twelve wraps and
   // carries a year.
   assign base_mon_wrap = req_data.base_months > cdta_pkg::MONTH_DEC;
   always_comb begin
      if (req_data.base_months == 4'd0) begin
         base_mon = cdta_pkg::MONTH_JAN;
      end else if (base_mon_wrap) begin
         base_mon = req_data.base_months - cdta_pkg::MONTH_DEC;
      end else begin
         base_mon = req_data.base_months;
      end
   end

   // Operand selection for the shared unit.
   always_comb begin
      sub_op = '0;
      case (state_ff)
         ST_MIN: begin
            sub_op.minuend    = min_ff;
            sub_op.subtrahend = cdta_pkg::MINUTES_PER_HOUR;
         end
         ST_HR: begin
            sub_op.minuend    = hr_ff;
            sub_op.subtrahend = cdta_pkg::HOURS_PER_DAY;
         end
         ST_DAY: begin
            sub_op.minuend    = day_ff;
            sub_op.subtrahend = dim;
         end
         ST_MON: begin
            sub_op.minuend    = mon_ff;
            sub_op.subtrahend = cdta_pkg::MONTHS_PER_YEAR;
         end
         ST_YR: begin
            sub_op.minuend    = yr_ff;
            sub_op.subtrahend = cdta_pkg::YEARS_PER_CENT;
         end
         default: begin
            sub_op = '0;
         end
      endcase
   end

   cdta_sub_unit u_sub (
      .op  (sub_op),
      .res (sub_res)
   );

   // Sequencer and datapath updates.
   always_comb begin
      state_in     = state_ff;
      min_in       = min_ff;
      hr_in        = hr_ff;
      day_in       = day_ff;
      mon_in       = mon_ff;
      yr_in        = yr_ff;
      add_mon_in   = add_mon_ff;
      add_yr_in    = add_yr_ff;
      cent_in      = cent_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // Base and added minutes, hours and days are summed up front; the
               // carries are worked out one subtraction at a time afterwards.
               min_in     = 9'(req_data.base_minutes) + 9'(req_data.add_minutes);
               hr_in      = 9'(req_data.base_hours) + 9'(req_data.add_hours);
               day_in     = 9'(req_data.base_days) + 9'(req_data.add_days);
               mon_in     = 9'(base_mon);
               yr_in      = 9'(req_data.base_years) + 9'(base_mon_wrap);
               add_mon_in = req_data.add_months;
               add_yr_in  = req_data.add_years;
               cent_in    = 1'b0;
               state_in   = ST_MIN;
            end
         end
         ST_MIN: begin
            if (sub_res.ge) begin
               min_in = sub_res.diff;
               hr_in  = hr_ff + 9'd1;
            end else begin
               state_in = ST_HR;
            end
         end
         ST_HR: begin
            if (sub_res.ge) begin
               hr_in  = sub_res.diff;
               day_in = day_ff + 9'd1;
            end else begin
               state_in = ST_DAY;
            end
         end
         ST_DAY: begin
            if (sub_res.gt) begin
               day_in = sub_res.diff;
               if (mon_ff[3:0] == cdta_pkg::MONTH_DEC) begin
                  mon_in = 9'(cdta_pkg::MONTH_JAN);
                  yr_in  = yr_ff + 9'd1;
               end else begin
                  mon_in = mon_ff + 9'd1;
               end
            end else begin
               // Months and years are added once the days are settled.
               mon_in   = mon_ff + 9'(add_mon_ff) - 9'd1;
               yr_in    = yr_ff + 9'(add_yr_ff);
               state_in = ST_MON;
            end
         end
         ST_MON: begin
            if (sub_res.ge) begin
               mon_in = sub_res.diff;
               yr_in  = yr_ff + 9'd1;
            end else begin
               state_in = ST_YR;
            end
         end
         ST_YR: begin
            if (sub_res.ge) begin
               yr_in   = sub_res.diff;
               cent_in = 1'b1;
            end else begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.sum_minutes = min_ff[5:0];
               rsp_data_in.sum_hours   = hr_ff[4:0];
               rsp_data_in.sum_days    = day_ff[4:0];
               rsp_data_in.sum_months  = mon_ff[3:0] + 4'd1;
               rsp_data_in.sum_years   = yr_ff[6:0];
               rsp_data_in.century_out = cent_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff      <= min_in;
      hr_ff       <= hr_in;
      day_ff      <= day_in;
      mon_ff      <= mon_in;
      yr_ff       <= yr_in;
      add_mon_ff  <= add_mon_in;
      add_yr_ff   <= add_yr_in;
      cent_ff     <= cent_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // A response only follows the end of the year phase.
   a_rsp_after_year: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_YR))
      else $error("response strobe without a finished year phase");

   // The response strobe never overlaps work on a request.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   // The day rollover only ever sees a calendar month.
   a_day_month_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DAY |-> (mon_ff >= 9'd1 && mon_ff <= 9'd12))
      else $error("month out of range during day rollover");

   // Normalized time of day in every response.
   a_rsp_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.sum_minutes < 6'd60 && rsp_data.sum_hours < 5'd24))
      else $error("response time of day not normalized");
`endif

endmodule

/* dv/tb_calendar_date_time_adder_top.sv */
// ----------------------------------------------------------------------------
// tb_calendar_date_time_adder_top
// Self-checking bench for the calendar date-time adder. Directed corner
// requests come first, then random calendar requests, a back-to-back burst
// and random out-of-range requests. Every accepted request is run through
// a local date arithmetic predictor, and each response strobe is checked
// field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_calendar_date_time_adder_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Calendar constants used by the predictor.
   localparam int unsigned MIN_PER_HOUR  = 60;
   localparam int unsigned HOUR_PER_DAY  = 24;
   localparam int unsigned MON_PER_YEAR  = 12;
   localparam int unsigned YEAR_PER_CENT = 100;
   localparam int unsigned LEAP_SPAN     = 4;
   localparam int unsigned FEB           = 2;
   localparam int unsigned FEB_LEAP_LEN  = 29;

   // Cycles without any accepted request or response before giving up; sender
   // gaps are short.
   localparam int unsigned STALL_LIMIT   = 2000;
   // Quiet cycles after the last response.
   localparam int unsigned DRAIN_CYCLES  = 80;
   localparam int unsigned REPORT_LIMIT  = 10;

   localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   cdta_pkg::req_type req_data;
   logic              rsp_valid;
   cdta_pkg::rsp_type rsp_data;

   // Predicted sums, oldest first, one per accepted request.
   cdta_pkg::rsp_type expected_sums[$];
   int unsigned       requests_sent;
   int unsigned       sums_checked;
   int unsigned       mismatch_count;
   int unsigned       stall_cycles;
   // Set during the burst test so the sender keeps start high throughout.
   bit                no_gaps;

   calendar_date_time_adder_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // February gets its leap day whenever the running year total is a
   // multiple of four, including year totals past the century.
   function automatic int unsigned days_in(input int unsigned month, input int unsigned year);
      if (month == FEB && (year % LEAP_SPAN) == 0) begin
         return FEB_LEAP_LEN;
      end
      return MONTH_DAYS[(month - 1) % MON_PER_YEAR];
   endfunction

   // Normalizes base plus interval in the block's order: minutes, hours,
   // days rolled month by month, then months, then years. The day is not
   // clipped after the months are added, so it may overrun the final month.
   function automatic cdta_pkg::rsp_type calc_date_sum(input cdta_pkg::req_type r);
      int unsigned       mins;
      int unsigned       hrs;
      int unsigned       dd;
      int unsigned       mm;
      int unsigned       yy;
      int unsigned       mlen;
      cdta_pkg::rsp_type s;
      mins = 32'(r.base_minutes);
      hrs  = 32'(r.base_hours);
      dd   = 32'(r.base_days);
      mm   = 32'(r.base_months);
      yy   = 32'(r.base_years);

      // A month of zero reads as January; months 13 to 15 carry a year.
      if (mm == 0) begin
         mm = 1;
      end else if (mm > MON_PER_YEAR) begin
         mm = mm - MON_PER_YEAR;
         yy = yy + 1;
      end

      mins = mins + 32'(r.add_minutes);
      hrs  = hrs + mins / MIN_PER_HOUR;
      mins = mins % MIN_PER_HOUR;

      hrs = hrs + 32'(r.add_hours);
      dd  = dd + hrs / HOUR_PER_DAY;
      hrs = hrs % HOUR_PER_DAY;

      dd   = dd + 32'(r.add_days);
      mlen = days_in(mm, yy);
      while (dd > mlen) begin
         dd = dd - mlen;
         mm = mm + 1;
         if (mm > MON_PER_YEAR) begin
            mm = 1;
            yy = yy + 1;
         end
         mlen = days_in(mm, yy);
      end

      mm = mm + 32'(r.add_months);
      yy = yy + (mm - 1) / MON_PER_YEAR;
      mm = (mm - 1) % MON_PER_YEAR + 1;

      yy = yy + 32'(r.add_years);

      s.sum_minutes = 6'(mins);
      s.sum_hours   = 5'(hrs);
      s.sum_days    = 5'(dd);
      s.sum_months  = 4'(mm);
      s.sum_years   = 7'(yy % YEAR_PER_CENT);
      s.century_out = (yy >= YEAR_PER_CENT);
      return s;
   endfunction

   // ------------------------------------------------------------------------
   // Request helpers
   // ------------------------------------------------------------------------

   function automatic cdta_pkg::req_type make_req(
      input int unsigned bmin, input int unsigned bhr, input int unsigned bday,
      input int unsigned bmon, input int unsigned byr,
      input int unsigned amin, input int unsigned ahr, input int unsigned aday,
      input int unsigned amon, input int unsigned ayr);
      cdta_pkg::req_type r;
      r.base_minutes = 6'(bmin);
      r.base_hours   = 5'(bhr);
      r.base_days    = 5'(bday);
      r.base_months  = 4'(bmon);
      r.base_years   = 7'(byr);
      r.add_minutes  = 8'(amin);
      r.add_hours    = 8'(ahr);
      r.add_days     = 8'(aday);
      r.add_months   = 8'(amon);
      r.add_years    = 7'(ayr);
      return r;
   endfunction

   // A date-time with each field in range and a random interval. Now and then the
   // interval is kept small so that single carries and month ends show up.
   function automatic cdta_pkg::req_type random_calendar_req();
      int unsigned span;
      span = ($urandom_range(3) == 0) ? 3 : 255;
      return make_req($urandom_range(59), $urandom_range(23), $urandom_range(31, 1),
                      $urandom_range(12, 1), $urandom_range(99),
                      $urandom_range(span), $urandom_range(span), $urandom_range(span),
                      $urandom_range(span), $urandom_range(99));
   endfunction

   // Drives one request from a falling edge, with random idle cycles in
   // front of it unless the burst test is running, and holds it until the
   // rising edge at which busy is low. The prediction is queued right there.
   task automatic send_request(input cdta_pkg::req_type item);
      @(negedge clock);
      if (!no_gaps) begin
         while ($urandom_range(99) < 32) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= item;
      do begin
         @(posedge clock);
      end while (busy);
      expected_sums.push_back(calc_date_sum(item));
      requests_sent++;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   task automatic test_directed_corners();
      // All zero: month zero reads as January and day zero stays zero.
      send_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // One minute past the last minute of the century.
      send_request(make_req(59, 23, 31, 12, 99, 1, 0, 0, 0, 0));
      // Largest legal base with the largest interval but for 99 added years.
      send_request(make_req(59, 23, 31, 12, 99, 255, 255, 255, 255, 99));
      // Every field at all ones, far out of range.
      send_request(make_req(63, 31, 31, 15, 127, 255, 255, 255, 255, 127));
      // Base month above twelve carries into the year.
      send_request(make_req(10, 5, 15, 13, 42, 0, 0, 0, 0, 0));
      send_request(make_req(0, 0, 28, 14, 99, 0, 0, 1, 0, 0));
      // Base month zero with enough days to roll past January.
      send_request(make_req(30, 12, 20, 0, 7, 0, 0, 40, 0, 0));
      // Base day zero with a carry from the hours.
      send_request(make_req(0, 23, 0, 5, 10, 0, 1, 0, 0, 0));
      // Base day beyond the length of February is rolled into March.
      send_request(make_req(0, 0, 31, 2, 3, 0, 0, 0, 0, 0));
      // February end in a leap year and in a common year.
      send_request(make_req(0, 0, 28, 2, 24, 0, 0, 1, 0, 0));
      send_request(make_req(0, 0, 28, 2, 23, 0, 0, 1, 0, 0));
      send_request(make_req(0, 0, 29, 2, 0, 0, 0, 1, 0, 0));
      // Minutes and hours above range in the base.
      send_request(make_req(63, 31, 1, 1, 0, 0, 0, 0, 0, 0));
      // A month added to January 31 leaves the day beyond February.
      send_request(make_req(0, 0, 31, 1, 1, 0, 0, 0, 1, 0));
      // Years alone push past the century.
      send_request(make_req(0, 0, 1, 1, 0, 0, 0, 0, 0, 127));
      send_request(make_req(0, 0, 1, 1, 127, 0, 0, 0, 0, 0));
      // Many month carries from December.
      send_request(make_req(0, 0, 1, 12, 50, 0, 0, 0, 255, 0));
      // A full day of hours at New Year's Eve.
      send_request(make_req(59, 23, 31, 12, 49, 0, 24, 0, 0, 0));
      // Last day of a 30-day month.
      send_request(make_req(0, 0, 30, 4, 5, 0, 0, 1, 0, 0));
      // Alternating bit patterns in every field and their complements.
      send_request(make_req(42, 21, 21, 10, 85, 170, 85, 170, 85, 42));
      send_request(make_req(21, 10, 10, 5, 42, 85, 170, 85, 170, 85));
   endtask

   task automatic test_calendar_random(input int unsigned count);
      repeat (count) begin
         send_request(random_calendar_req());
      end
   endtask

   // Any bit pattern in any field, so every special case of the base can
   // occur: month zero or above twelve, day zero, over-range time fields.
   task automatic test_out_of_range_random(input int unsigned count);
      cdta_pkg::req_type r;
      repeat (count) begin
         r.base_minutes = 6'($urandom);
         r.base_hours   = 5'($urandom);
         r.base_days    = 5'($urandom);
         r.base_months  = 4'($urandom);
         r.base_years   = 7'($urandom);
         r.add_minutes  = 8'($urandom);
         r.add_hours    = 8'($urandom);
         r.add_days     = 8'($urandom);
         r.add_months   = 8'($urandom);
         r.add_years    = 7'($urandom);
         send_request(r);
      end
   endtask

   // Start stays high for the whole burst, so each new request is taken in
   // the cycle of the previous response.
   task automatic test_back_to_back(input int unsigned count);
      no_gaps = 1'b1;
      repeat (count) begin
         send_request(random_calendar_req());
      end
      no_gaps = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Response checking
   // ------------------------------------------------------------------------

   task automatic check_field(input string field, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch in %s of result %0d: expected %0d, got %0d",
                     $realtime, field, sums_checked, want, got);
         end
      end
   endtask

   // Responses cannot be held off, so each strobe is taken at the rising
   // edge that ends its cycle and compared with the oldest prediction.
   always @(posedge clock) begin
      cdta_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_sums.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: response with no request outstanding: %p",
                        $realtime, rsp_data);
            end
         end else begin
            want = expected_sums.pop_front();
            check_field("sum_minutes", 8'(rsp_data.sum_minutes), 8'(want.sum_minutes));
            check_field("sum_hours",   8'(rsp_data.sum_hours),   8'(want.sum_hours));
            check_field("sum_days",    8'(rsp_data.sum_days),    8'(want.sum_days));
            check_field("sum_months",  8'(rsp_data.sum_months),  8'(want.sum_months));
            check_field("sum_years",   8'(rsp_data.sum_years),   8'(want.sum_years));
            check_field("century_out", 8'(rsp_data.century_out), 8'(want.century_out));
            sums_checked++;
         end
      end
   end

   // The watchdog restarts whenever a request or a response is accepted.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("Timeout: no progress for %0d cycles, %0d responses outstanding",
                     STALL_LIMIT, expected_sums.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      no_gaps        = 1'b0;
      requests_sent  = 0;
      sums_checked   = 0;
      mismatch_count = 0;
      stall_cycles   = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_calendar_random(850);
      test_back_to_back(150);
      test_out_of_range_random(330);

      @(negedge clock);
      start <= 1'b0;
      while (expected_sums.size() != 0) begin
         @(posedge clock);
      end
      // Any stray response after the last expected one shows up here.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: directed corners, calendar dates, a back-to-back burst",
               requests_sent);
      $display("and raw out-of-range fields; %0d responses checked, %0d mismatches.",
               sums_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
